[rtl/core/cvbb_pkg.sv]
// Package for the column validity bitmap builder.
// Holds field widths, operation and kind codes, and the bitmap encoding function.
// No dependencies.
`default_nettype none

package cvbb_pkg;

    localparam int DEFAULT_MAX_ROWS = 4096;

    // Field widths fixed by the stream format.
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int VBITS_W  = 64;
    localparam int VLEN_W   = 16;
    localparam int RIDX_W   = 12;
    localparam int CNT_W    = 13;
    localparam int OFFS_W   = 31;
    localparam int SEEN_W   = 3;
    localparam int CODE_W   = 2;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 1;

    localparam logic [OFFS_W-1:0] OFFSET_MAX = {OFFS_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_START = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE = 2'd0,
        KIND_NONE  = 2'd1,
        KIND_NULL  = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    // Canonical stored code per entry.
    localparam logic [CODE_W-1:0] CODE_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] CODE_NULL  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_VALUE = 2'd2;

    // Bits of the seen-kinds set.
    localparam logic [SEEN_W-1:0] SEEN_NONE  = 3'b001;
    localparam logic [SEEN_W-1:0] SEEN_NULL  = 3'b010;
    localparam logic [SEEN_W-1:0] SEEN_VALUE = 3'b100;
    localparam logic [SEEN_W-1:0] SEEN_ALL   = 3'b111;

    // Config register indexes.
    localparam logic CFG_IS_VAR      = 1'b0;
    localparam logic CFG_COUNT_NULLS = 1'b1;

    // Translates a canonical code into the bitmap encoding implied by the seen set.
    function automatic logic [CODE_W-1:0] encode_code(
        input logic [SEEN_W-1:0] seen,
        input logic [CODE_W-1:0] code
    );
        logic [CODE_W-1:0] res;
        begin
            res = '0;
            if (seen == SEEN_ALL)
            begin
                res = code;
            end
            else if (seen == (SEEN_NONE | SEEN_NULL))
            begin
                res = {1'b0, code == CODE_NULL};
            end
            else if (seen == (SEEN_VALUE | SEEN_NONE) || seen == (SEEN_VALUE | SEEN_NULL))
            begin
                res = {1'b0, code == CODE_VALUE};
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/cvbb_code_mem.sv]
// Kind code store: one canonical 2-bit code per entry of the current block.
// One write port and one read port with registered read data. Uses cvbb_pkg.
`default_nettype none

module cvbb_code_mem
    import cvbb_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_ROWS,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [CODE_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [CODE_W-1:0] rd_data
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/column_validity_bitmap_builder_unit.sv]
// Column validity bitmap builder, top level.
// Instantiates cvbb_code_mem; uses cvbb_pkg.
//
//   channel   direction  transfer when            content
//   s_*       in         s_tvalid & s_tready      one command: add, read or block start
//   m_*       out        m_tvalid & m_tready      one result per command
//   cfg_*     in         cfg_we high              is_var_type, count_nulls
//
// For every command the block state updates at the input transfer and the
// result lands in the output register, with a read's code taken from the code store's
// registered port in the same edge. A new command is taken each cycle while the output
// register is empty or being drained. Reset clears the counters, seen set and output
// valid; the code store is not cleared, since only entries of the current block are read.
`default_nettype none

module column_validity_bitmap_builder_unit
    import cvbb_pkg::*;
#(
    parameter int MAX_ROWS = DEFAULT_MAX_ROWS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // value_bits[63:0], value_length[79:64], read_index[91:80], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // op[1:0], kind[3:2]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // fill_count[12:0], value_out[76:13], value_offset[107:77], kinds_seen[110:108],
    // entry_total[123:111], null_total[136:124], bitmap_code[138:137],
    // two_bit_mode[139], overflow[140], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    // emit_value[0]
    output logic [M_TUSER_W-1:0]      m_tuser,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic                 cfg_data
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam logic [CW-1:0] ROWS_FULL = CW'(MAX_ROWS);

    typedef struct packed {
        logic              emit;
        logic [CNT_W-1:0]  fill;
        logic [VBITS_W-1:0] vout;
        logic [OFFS_W-1:0] offs;
        logic [SEEN_W-1:0] seen;
        logic [CNT_W-1:0]  entries;
        logic [CNT_W-1:0]  nulls;
        logic              rd_hit;
        logic              ovf;
    } result_t;

    // Input fields.
    op_t               op;
    kind_t             kind;
    logic [VBITS_W-1:0] vbits;
    logic [VLEN_W-1:0] vlen;
    logic [RIDX_W-1:0] ridx;

    assign op    = op_t'(s_tuser[1:0]);
    assign kind  = kind_t'(s_tuser[3:2]);
    assign vbits = s_tdata[63:0];
    assign vlen  = s_tdata[79:64];
    assign ridx  = s_tdata[91:80];

    // Configuration and block state.
    logic              is_var_reg;
    logic              count_nulls_reg;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [CW-1:0]     entry_count_reg, entry_count_next;
    logic [CW-1:0]     null_count_reg, null_count_next;
    logic [OFFS_W-1:0] byte_offset_reg, byte_offset_next;

    result_t           res_reg, res_next;
    logic              out_valid_reg;

    logic              accept;
    logic              is_add, add_ok;
    logic [CODE_W-1:0] canon;
    logic [SEEN_W-1:0] kind_bit;
    logic [OFFS_W:0]   offs_sum;
    logic [VLEN_W-1:0] offs_add;
    logic              rd_en;
    logic [CW+RIDX_W-1:0] ridx_ext, count_ext;
    logic [AW+RIDX_W-1:0] raddr_ext;
    logic [CW+CNT_W-1:0]  fill_ext, ent_ext, null_ext;
    logic [CODE_W-1:0] rd_code;
    logic [CODE_W-1:0] code_out;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        case (kind)
            KIND_VALUE:
            begin
                canon    = CODE_VALUE;
                kind_bit = SEEN_VALUE;
            end
            KIND_NONE:
            begin
                canon    = CODE_NONE;
                kind_bit = SEEN_NONE;
            end
            KIND_NULL:
            begin
                canon    = CODE_NULL;
                kind_bit = SEEN_NULL;
            end
            default:
            begin
                canon    = CODE_NONE;
                kind_bit = '0;
            end
        endcase
    end

    assign is_add = (op == OP_ADD) && (kind != KIND_BAD);
    assign add_ok = is_add && (entry_count_reg != ROWS_FULL);

    assign offs_add = (kind == KIND_VALUE) ? vlen : '0;
    assign offs_sum = {1'b0, byte_offset_reg} + {{(OFFS_W + 1 - VLEN_W){1'b0}}, offs_add};

    assign ridx_ext  = {{CW{1'b0}}, ridx};
    assign count_ext = {{RIDX_W{1'b0}}, entry_count_reg};
    assign raddr_ext = {{AW{1'b0}}, ridx};
    assign fill_ext  = {{CNT_W{1'b0}}, entry_count_reg};
    assign rd_en     = accept && (op == OP_READ);

    always_comb
    begin
        seen_next        = seen_reg;
        entry_count_next = entry_count_reg;
        null_count_next  = null_count_reg;
        byte_offset_next = byte_offset_reg;
        res_next         = '0;

        case (op)
            OP_ADD:
            begin
                if (add_ok)
                begin
                    seen_next        = seen_reg | kind_bit;
                    entry_count_next = entry_count_reg + CW'(1);
                    if (count_nulls_reg && !is_var_reg && kind != KIND_VALUE)
                    begin
                        null_count_next = null_count_reg + CW'(1);
                    end
                    if (kind == KIND_VALUE && !seen_reg[2])
                    begin
                        res_next.fill = fill_ext[CNT_W-1:0];
                    end
                    // Once a value has been seen, every entry sends one.
                    if (seen_next[2])
                    begin
                        res_next.emit = 1'b1;
                        if (kind == KIND_VALUE)
                        begin
                            res_next.vout = vbits;
                        end
                        if (is_var_reg)
                        begin
                            res_next.offs    = byte_offset_reg;
                            byte_offset_next = offs_sum[OFFS_W] ? OFFSET_MAX
                                                                : offs_sum[OFFS_W-1:0];
                        end
                    end
                end
                res_next.ovf = is_add && !add_ok;
            end
            OP_READ:
            begin
                res_next.rd_hit = ridx_ext < count_ext;
            end
            OP_START:
            begin
                seen_next        = '0;
                entry_count_next = '0;
                null_count_next  = '0;
                byte_offset_next = '0;
            end
            default:
            begin
            end
        endcase

        ent_ext          = {{CNT_W{1'b0}}, entry_count_next};
        null_ext         = {{CNT_W{1'b0}}, null_count_next};
        res_next.seen    = seen_next;
        res_next.entries = ent_ext[CNT_W-1:0];
        res_next.nulls   = null_ext[CNT_W-1:0];
    end

    cvbb_code_mem #(
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_code_mem (
        .clk     (clk),
        .wr_en   (accept && add_ok),
        .wr_addr (entry_count_reg[AW-1:0]),
        .wr_data (canon),
        .rd_en   (rd_en),
        .rd_addr (raddr_ext[AW-1:0]),
        .rd_data (rd_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_var_reg      <= 1'b0;
            count_nulls_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IS_VAR:      is_var_reg      <= cfg_data;
                CFG_COUNT_NULLS: count_nulls_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg        <= '0;
            entry_count_reg <= '0;
            null_count_reg  <= '0;
            byte_offset_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                seen_reg        <= seen_next;
                entry_count_reg <= entry_count_next;
                null_count_reg  <= null_count_next;
                byte_offset_reg <= byte_offset_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // The seen set does not change on a read, so the stored set gives the read's encoding.
    assign code_out = res_reg.rd_hit ? encode_code(res_reg.seen, rd_code) : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.emit;
    assign m_tdata  = {3'b000,
                       res_reg.ovf,
                       res_reg.seen == SEEN_ALL,
                       code_out,
                       res_reg.nulls,
                       res_reg.entries,
                       res_reg.seen,
                       res_reg.offs,
                       res_reg.vout,
                       res_reg.fill};

endmodule

`default_nettype wire

[tb/column_validity_bitmap_builder_unit_test.sv]
// Self-checking testbench for column_validity_bitmap_builder_unit.
// Drives commands on the slave stream, predicts each result and checks the master stream.
// Depends on cvbb_pkg and the block's RTL only.
`default_nettype none

module column_validity_bitmap_builder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cvbb_pkg::*;

    localparam int ROWS         = DEFAULT_MAX_ROWS;
    localparam int PHASE_ITEMS  = 225;
    localparam int PHASE_COUNT  = 8;
    localparam int SETTLE_TICKS = 5;

    typedef struct {
        op_t                op;
        kind_t              kind;
        logic [VBITS_W-1:0] vbits;
        logic [VLEN_W-1:0]  vlen;
        logic [RIDX_W-1:0]  idx;
    } cmd_t;

    typedef struct {
        logic               emit;
        logic [CNT_W-1:0]   fill;
        logic [VBITS_W-1:0] vout;
        logic [OFFS_W-1:0]  offs;
        logic [SEEN_W-1:0]  seen;
        logic [CNT_W-1:0]   entries;
        logic [CNT_W-1:0]   nulls;
        logic [CODE_W-1:0]  code;
        logic               two_bit;
        logic               ovf;
    } result_t;

    typedef struct {
        cmd_t    c;
        bit      lit;
        result_t want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_we;
    logic                 cfg_index;
    logic                 cfg_data;

    // Predicted column state and configuration.
    logic               var_column;
    logic               stats_on;
    logic [SEEN_W-1:0]  col_seen;
    int                 col_entries;
    int                 col_nulls;
    logic [OFFS_W-1:0]  col_offset;
    logic [CODE_W-1:0]  col_codes [ROWS];
    int                 high_water;
    logic [SEEN_W-1:0]  block_mix;

    result_t pending_results [$];
    int      mismatches;
    int      send_idle_pct;
    int      stall_pct;

    column_validity_bitmap_builder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [CODE_W-1:0] bitmap_read(logic [CODE_W-1:0] canon);
        logic [CODE_W-1:0] enc;
        enc = '0;
        case (col_seen)
            SEEN_ALL: enc = canon;
            SEEN_NONE | SEEN_NULL: enc = (canon == CODE_NULL) ? 2'd1 : 2'd0;
            SEEN_VALUE | SEEN_NONE, SEEN_VALUE | SEEN_NULL:
                enc = (canon == CODE_VALUE) ? 2'd1 : 2'd0;
            default: enc = '0;
        endcase
        return enc;
    endfunction

    // Applies one accepted command to the predicted column and returns its result.
    function automatic result_t column_step(cmd_t c);
        result_t           r;
        logic              had_value;
        logic [SEEN_W-1:0] kind_bit;
        logic [CODE_W-1:0] canon;
        logic [OFFS_W-1:0] grow;
        r = '{default: '0};
        case (c.op)
            OP_ADD:
            begin
                if (c.kind != KIND_BAD)
                begin
                    if (col_entries >= ROWS)
                    begin
                        r.ovf = 1'b1;
                    end
                    else
                    begin
                        kind_bit = (c.kind == KIND_VALUE) ? SEEN_VALUE :
                                   (c.kind == KIND_NONE)  ? SEEN_NONE  : SEEN_NULL;
                        canon = (c.kind == KIND_VALUE) ? CODE_VALUE :
                                (c.kind == KIND_NONE)  ? CODE_NONE  : CODE_NULL;
                        had_value = col_seen[2];
                        if (stats_on && !var_column && c.kind != KIND_VALUE)
                            col_nulls++;
                        if (c.kind == KIND_VALUE && !had_value)
                            r.fill = CNT_W'(col_entries);
                        col_seen = col_seen | kind_bit;
                        if (col_seen[2])
                        begin
                            r.emit = 1'b1;
                            if (c.kind == KIND_VALUE)
                                r.vout = c.vbits;
                            if (var_column)
                            begin
                                grow = (c.kind == KIND_VALUE) ? OFFS_W'(c.vlen) : '0;
                                r.offs = col_offset;
                                if (col_offset > OFFSET_MAX - grow)
                                    col_offset = OFFSET_MAX;
                                else
                                    col_offset = col_offset + grow;
                            end
                        end
                        col_codes[col_entries] = canon;
                        col_entries++;
                        if (col_entries > high_water)
                            high_water = col_entries;
                    end
                end
            end
            OP_READ:
            begin
                if (c.idx < col_entries)
                    r.code = bitmap_read(col_codes[c.idx]);
            end
            OP_START:
            begin
                col_seen    = '0;
                col_entries = 0;
                col_nulls   = 0;
                col_offset  = '0;
            end
            default: ;
        endcase
        r.seen    = col_seen;
        r.entries = CNT_W'(col_entries);
        r.nulls   = CNT_W'(col_nulls);
        r.two_bit = (col_seen == SEEN_ALL);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VBITS_W-1:0] got,
                                   input logic [VBITS_W-1:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input result_t got, input result_t want);
        if (got.emit !== want.emit)
            report_mismatch("emit_value", VBITS_W'(got.emit), VBITS_W'(want.emit));
        if (got.fill !== want.fill)
            report_mismatch("fill_count", VBITS_W'(got.fill), VBITS_W'(want.fill));
        if (got.vout !== want.vout)
            report_mismatch("value_out", got.vout, want.vout);
        if (got.offs !== want.offs)
            report_mismatch("value_offset", VBITS_W'(got.offs), VBITS_W'(want.offs));
        if (got.seen !== want.seen)
            report_mismatch("kinds_seen", VBITS_W'(got.seen), VBITS_W'(want.seen));
        if (got.entries !== want.entries)
            report_mismatch("entry_total", VBITS_W'(got.entries), VBITS_W'(want.entries));
        if (got.nulls !== want.nulls)
            report_mismatch("null_total", VBITS_W'(got.nulls), VBITS_W'(want.nulls));
        if (got.code !== want.code)
            report_mismatch("bitmap_code", VBITS_W'(got.code), VBITS_W'(want.code));
        if (got.two_bit !== want.two_bit)
            report_mismatch("two_bit_mode", VBITS_W'(got.two_bit), VBITS_W'(want.two_bit));
        if (got.ovf !== want.ovf)
            report_mismatch("overflow", VBITS_W'(got.ovf), VBITS_W'(want.ovf));
    endtask

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.fill    = m_tdata[12:0];
            got.vout    = m_tdata[76:13];
            got.offs    = m_tdata[107:77];
            got.seen    = m_tdata[110:108];
            got.entries = m_tdata[123:111];
            got.nulls   = m_tdata[136:124];
            got.code    = m_tdata[138:137];
            got.two_bit = m_tdata[139];
            got.ovf     = m_tdata[140];
            got.emit    = m_tuser[0];
            if (pending_results.size() == 0)
                report_mismatch("result transfer with nothing expected, entry_total",
                                VBITS_W'(got.entries), '0);
            else
                check_result(got, pending_results.pop_front());
        end
    end

    function automatic row_t plain(op_t op, kind_t kind, logic [VBITS_W-1:0] vbits,
                                   logic [VLEN_W-1:0] vlen, logic [RIDX_W-1:0] idx);
        row_t r;
        r.c    = '{op: op, kind: kind, vbits: vbits, vlen: vlen, idx: idx};
        r.lit  = 1'b0;
        r.want = '{default: '0};
        return r;
    endfunction

    // Row whose result is only status: no value emitted, no overflow.
    function automatic row_t fixed(row_t r, logic [SEEN_W-1:0] seen, int entries,
                                   logic [CODE_W-1:0] code);
        r.lit          = 1'b1;
        r.want.seen    = seen;
        r.want.entries = CNT_W'(entries);
        r.want.code    = code;
        r.want.two_bit = (seen == SEEN_ALL);
        return r;
    endfunction

    // Every call starts at a falling edge and returns at one after the transfer.
    task automatic send_cmd(input cmd_t c, input bit lit, input result_t want);
        result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 92){1'b0}}, c.idx, c.vlen, c.vbits};
        s_tuser  <= {c.kind, c.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = column_step(c);
        pending_results.push_back(lit ? want : r);
        @(negedge clk);
    endtask

    task automatic send_predicted(input cmd_t c);
        send_cmd(c, 1'b0, '{default: '0});
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_config(input logic is_var, input logic count_nulls);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IS_VAR;
        cfg_data  <= is_var;
        @(negedge clk);
        cfg_index <= CFG_COUNT_NULLS;
        cfg_data  <= count_nulls;
        @(negedge clk);
        cfg_we    <= 1'b0;
        var_column = is_var;
        stats_on   = count_nulls;
    endtask

    function automatic cmd_t random_cmd();
        cmd_t        c;
        int unsigned pick;
        logic [1:0]  k;
        pick    = $urandom_range(0, 99);
        c.op    = OP_ADD;
        c.kind  = KIND_VALUE;
        c.vbits = {$urandom, $urandom};
        c.vlen  = VLEN_W'($urandom_range(0, 65535));
        c.idx   = RIDX_W'($urandom_range(0, 4095));
        if (pick < 3)
        begin
            c.op      = OP_START;
            block_mix = SEEN_W'($urandom_range(1, 7));
        end
        else if (pick < 6)
        begin
            if ($urandom_range(0, 1) == 0)
                c.op = OP_NOP;
            else
                c.kind = KIND_BAD;
        end
        else if (pick < 22)
        begin
            c.op = OP_READ;
            // Reads stay on entries written at some point since reset.
            if (col_entries > 0 && (high_water == col_entries || $urandom_range(0, 3) != 0))
                c.idx = RIDX_W'($urandom_range(0, col_entries - 1));
            else if (high_water > col_entries)
                c.idx = RIDX_W'($urandom_range(col_entries, high_water - 1));
            else
                c.op = OP_NOP;
        end
        else
        begin
            // Each block draws its kinds from one mix, so every encoding shows up.
            do
                k = 2'($urandom_range(0, 2));
            while (!block_mix[k == 2'd0 ? 2 : (k == 2'd1 ? 0 : 1)]);
            c.kind = kind_t'(k);
        end
        return c;
    endfunction

    // Fills a whole block, with a single value at value_pos (none if beyond the end),
    // then tries adds on the full column and reads across it.
    task automatic fill_column(input int value_pos);
        cmd_t c;
        send_predicted(plain(OP_START, KIND_VALUE, '0, '0, '0).c);
        for (int i = 0; i < ROWS; i++)
        begin
            c = plain(OP_ADD, kind_t'($urandom_range(1, 2)), {$urandom, $urandom},
                      VLEN_W'($urandom_range(0, 65535)), '0).c;
            if (i == value_pos)
                c.kind = KIND_VALUE;
            send_predicted(c);
        end
        for (int k = 0; k < 4; k++)
            send_predicted(plain(OP_ADD, kind_t'(k), {$urandom, $urandom}, 16'hFFFF, '0).c);
        send_predicted(plain(OP_READ, KIND_VALUE, '0, '0, 12'hFFF).c);
        send_predicted(plain(OP_READ, KIND_VALUE, '0, '0, 12'h000).c);
        for (int k = 0; k < 16; k++)
            send_predicted(plain(OP_READ, KIND_VALUE, '0, '0,
                                 RIDX_W'($urandom_range(0, 4095))).c);
    endtask

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        row_t table_rows [$];
        int   mode;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_IS_VAR;
        cfg_data      = 1'b0;
        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        var_column    = 1'b0;
        stats_on      = 1'b0;
        col_seen      = '0;
        col_entries   = 0;
        col_nulls     = 0;
        col_offset    = '0;
        high_water    = 0;
        block_mix     = 3'b111;

        table_rows.push_back(fixed(plain(OP_NOP, KIND_VALUE, '0, '0, '0), 3'b000, 0, 0));
        table_rows.push_back(fixed(plain(OP_START, KIND_VALUE, '0, '0, '0), 3'b000, 0, 0));
        table_rows.push_back(fixed(plain(OP_ADD, KIND_NONE, '1, '1, '1), 3'b001, 1, 0));
        table_rows.push_back(fixed(plain(OP_ADD, KIND_NULL, '1, '1, '1), 3'b011, 2, 0));
        table_rows.push_back(fixed(plain(OP_READ, KIND_VALUE, '0, '0, 0), 3'b011, 2, 0));
        table_rows.push_back(fixed(plain(OP_READ, KIND_VALUE, '0, '0, 1), 3'b011, 2, 1));
        // The first value back-fills the two earlier entries.
        table_rows.push_back(plain(OP_ADD, KIND_VALUE, '1, '1, '0));
        table_rows.push_back(plain(OP_ADD, KIND_BAD, 64'h0123_4567_89AB_CDEF, 16'h1234, '0));
        table_rows.push_back(plain(OP_ADD, KIND_NONE, 64'hDEAD_BEEF_0000_FFFF, 16'h00FF, '0));
        table_rows.push_back(plain(OP_READ, KIND_VALUE, '0, '0, 0));
        table_rows.push_back(plain(OP_READ, KIND_VALUE, '0, '0, 1));
        table_rows.push_back(plain(OP_READ, KIND_VALUE, '0, '0, 2));
        table_rows.push_back(plain(OP_ADD, KIND_VALUE, '0, '0, '0));
        table_rows.push_back(plain(OP_READ, KIND_VALUE, '0, '0, 4));
        table_rows.push_back(plain(OP_NOP, KIND_BAD, '1, '1, '1));
        table_rows.push_back(fixed(plain(OP_START, KIND_VALUE, '0, '0, '0), 3'b000, 0, 0));
        // Entry 1 still holds an old code but lies beyond the new count.
        table_rows.push_back(fixed(plain(OP_READ, KIND_VALUE, '0, '0, 1), 3'b000, 0, 0));
        table_rows.push_back(plain(OP_ADD, KIND_VALUE, 64'h8000_0000_0000_0001, 16'h8000,
                                   '0));
        table_rows.push_back(plain(OP_ADD, KIND_VALUE, 64'h7FFF_FFFF_FFFF_FFFE, 16'h7FFF,
                                   '0));
        table_rows.push_back(plain(OP_READ, KIND_VALUE, '0, '0, 1));
        table_rows.push_back(plain(OP_ADD, KIND_NULL, '0, '0, '0));
        table_rows.push_back(plain(OP_READ, KIND_VALUE, '0, '0, 2));
        table_rows.push_back(plain(OP_READ, KIND_VALUE, '0, '0, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (table_rows[i])
            send_cmd(table_rows[i].c, table_rows[i].lit, table_rows[i].want);

        drain();
        write_config(1'b0, 1'b1);
        fill_column(ROWS - 1);
        fill_column(ROWS);
        send_predicted(plain(OP_START, KIND_VALUE, '0, '0, '0).c);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            write_config(1'(p / 4), 1'(p % 2));
            mode          = p % 4;
            send_idle_pct = (mode == 1) ? 80 : (mode == 3) ? 27 : 0;
            stall_pct     = (mode == 2) ? 80 : (mode == 3) ? 27 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Now and then hold off until the output side has caught up.
                if ($urandom_range(0, 99) == 0)
                    drain();
                send_predicted(random_cmd());
            end
        end

        drain();
        repeat (SETTLE_TICKS) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
